>>> hdl/wlf_pkg.sv
// Shared types, constants and arithmetic helpers for the weighted line fit unit.
package wlf_pkg;

  localparam int W  = 192;  // magnitude width for the closing arithmetic
  localparam int QW = 49;   // quotient bits kept; anything above is sticky
  localparam int X_W = 20;
  localparam int WT_W = 8;
  localparam int OUT_W = 48;
  localparam int MIN_ITEMS = 2;
  localparam int MIN_USED = 3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_ZDEN = 2'd2;

  typedef struct packed {
    logic signed [X_W-1:0]  x_value;
    logic signed [X_W-1:0]  y_value;
    logic        [WT_W-1:0] weight;
    logic                   last_point;
  } wlf_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic        [OUT_W-1:0] variance;
    logic        [8:0]       points_used;
    logic        [1:0]       status;
  } wlf_out_t;

  typedef enum logic {OP_MUL, OP_DIV} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic big;
  } alu_rsp_t;

  // sign-magnitude number; zero always carries a clear sign
  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } swide_t;

  function automatic swide_t s_from64(input logic [63:0] v);
    swide_t r;
    logic [63:0] m;
    m = v[63] ? (64'd0 - v) : v;
    r.neg = v[63];
    r.mag = W'(m);
    return r;
  endfunction

  // a - b in sign-magnitude
  function automatic swide_t s_sub(input swide_t a, input swide_t b);
    swide_t r;
    logic bn;
    bn = ~b.neg;
    if (a.neg == bn) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = bn;
    end
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

  // signed Q32.16 from a truncated magnitude quotient, saturated
  function automatic logic [OUT_W-1:0] q16_signed(input logic neg, input logic [QW-1:0] q,
                                                  input logic big);
    logic [QW-1:0] lim;
    logic [OUT_W-1:0] mag;
    if (neg) begin
      lim = QW'(1) << (OUT_W - 1);
      mag = (big || q > lim) ? lim[OUT_W-1:0] : q[OUT_W-1:0];
      return OUT_W'(0) - mag;
    end
    lim = (QW'(1) << (OUT_W - 1)) - QW'(1);
    return (big || q > lim) ? lim[OUT_W-1:0] : q[OUT_W-1:0];
  endfunction

endpackage

>>> hdl/weighted_line_fit_variance_unit.sv
// Top level: weighted least-squares line fit with residual variance.
//
//  channel  | signals                          | beat taken when
//  ---------+----------------------------------+-------------------------
//  points   | start, busy, in_item             | start & !busy
//  results  | result_valid, result             | result_valid (no stall)
//  config   | cfg_valid, cfg_ready, cfg_data   | cfg_valid & cfg_ready
//
// One shared bit-serial multiply/divide unit does all multiplications and
// divisions. A used point costs six products. A skipped point, or one past
// the set limit, is taken without using the shared unit. The closing point
// adds up to twelve wide products and three 192-step divisions. Synchronous
// reset clears the sums, counters and skip_zero_y; no clearing pass is
// needed. Results are a one-cycle strobe and cannot be held off.
module weighted_line_fit_variance_unit import wlf_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  wlf_in_t  in_item,
  output logic     result_valid,
  output wlf_out_t result,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN, S_EMIT} state_t;

  // micro-ops run on the shared unit, in this order
  typedef enum logic [4:0] {
    ST_WW, ST_WX, ST_WY, ST_WXX, ST_WXY, ST_WYY,
    ST_D1, ST_D2, ST_N1, ST_N2, ST_B1, ST_B2, ST_SLOPE, ST_ICPT,
    ST_C1, ST_C2, ST_R1, ST_R2, ST_DEN1, ST_DEN2, ST_VAR
  } step_t;

  state_t state;
  step_t  step;
  logic   skip_zero_y;

  // running sums
  logic [24:0]      sum_w;
  logic [44:0]      sum_wx, sum_wy;
  logic [63:0]      sum_wxy, sum_wxx, sum_wyy;
  logic [CNT_W-1:0] items_seen, items_used;

  // current point
  logic [X_W-1:0]  x_abs, y_abs;
  logic            x_neg, y_neg, last;
  logic [WT_W-1:0] w_in;
  logic [15:0]     ww;
  logic [35:0]     wx, wy;

  // closing terms
  swide_t s_s, s_x, s_y, s_xx, s_xy, s_yy;
  swide_t t1, dd, nn, bn, cc, rr;
  logic [W-1:0] den;

  // shared unit
  alu_req_t      req;
  alu_rsp_t      rsp;
  logic [W-1:0]  opa, opb, prod;
  logic [QW-1:0] quo;
  logic          op_neg;
  swide_t        res, sub_new;
  logic [63:0]   contrib;
  logic [CNT_W-1:0] k_cnt;

  wlf_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .opa (opa),
    .opb (opb),
    .rsp (rsp),
    .prod(prod),
    .quo (quo)
  );

  assign k_cnt = items_used - CNT_W'(MIN_ITEMS);

  always_comb begin
    req.start = (state == S_ISSUE);
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    op_neg    = 1'b0;
    unique case (step)
      ST_WW:    begin opa = W'(w_in); opb = W'(w_in); end
      ST_WX:    begin opa = W'(ww); opb = W'(x_abs); op_neg = x_neg; end
      ST_WY:    begin opa = W'(ww); opb = W'(y_abs); op_neg = y_neg; end
      ST_WXX:   begin opa = W'(wx); opb = W'(x_abs); end
      ST_WXY:   begin opa = W'(wx); opb = W'(y_abs); op_neg = x_neg ^ y_neg; end
      ST_WYY:   begin opa = W'(wy); opb = W'(y_abs); end
      ST_D1:    begin opa = s_s.mag;  opb = s_xx.mag; op_neg = s_s.neg ^ s_xx.neg; end
      ST_D2:    begin opa = s_x.mag;  opb = s_x.mag;  end
      ST_N1:    begin opa = s_s.mag;  opb = s_xy.mag; op_neg = s_s.neg ^ s_xy.neg; end
      ST_N2:    begin opa = s_x.mag;  opb = s_y.mag;  op_neg = s_x.neg ^ s_y.neg; end
      ST_B1:    begin opa = s_xx.mag; opb = s_y.mag;  op_neg = s_xx.neg ^ s_y.neg; end
      ST_B2:    begin opa = s_x.mag;  opb = s_xy.mag; op_neg = s_x.neg ^ s_xy.neg; end
      ST_SLOPE: begin req.op = OP_DIV; opa = nn.mag << 16; opb = dd.mag; end
      ST_ICPT:  begin req.op = OP_DIV; opa = bn.mag << 16; opb = dd.mag; end
      ST_C1:    begin opa = s_s.mag;  opb = s_yy.mag; op_neg = s_s.neg ^ s_yy.neg; end
      ST_C2:    begin opa = s_y.mag;  opb = s_y.mag;  end
      ST_R1:    begin opa = cc.mag;   opb = dd.mag;   op_neg = cc.neg ^ dd.neg; end
      ST_R2:    begin opa = nn.mag;   opb = nn.mag;   end
      ST_DEN1:  begin opa = s_s.mag;  opb = dd.mag;   end
      ST_DEN2:  begin opa = den;      opb = W'(k_cnt); end
      ST_VAR:   begin req.op = OP_DIV; opa = rr.mag << 16; opb = den; end
      default:  begin opa = '0; end
    endcase
    res.mag = prod;
    res.neg = op_neg & (|prod);
    sub_new = s_sub(t1, res);
    contrib = res.neg ? (64'd0 - prod[63:0]) : prod[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= ST_WW;
      skip_zero_y  <= 1'b0;
      result_valid <= 1'b0;
      sum_w        <= '0;
      sum_wx       <= '0;
      sum_wy       <= '0;
      sum_wxy      <= '0;
      sum_wxx      <= '0;
      sum_wyy      <= '0;
      items_seen   <= '0;
      items_used   <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid) skip_zero_y <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x_neg <= in_item.x_value[X_W-1];
            y_neg <= in_item.y_value[X_W-1];
            x_abs <= in_item.x_value[X_W-1] ? X_W'(0) - in_item.x_value : in_item.x_value;
            y_abs <= in_item.y_value[X_W-1] ? X_W'(0) - in_item.y_value : in_item.y_value;
            w_in  <= in_item.weight;
            last  <= in_item.last_point;
            step  <= ST_WW;
            if (items_seen < CNT_W'(MAX_POINTS)) begin
              items_seen <= items_seen + CNT_W'(1);
              if (skip_zero_y && in_item.y_value == '0) begin
                state <= in_item.last_point ? S_FIN : S_IDLE;
              end else begin
                state <= S_ISSUE;
              end
            end else begin
              state <= in_item.last_point ? S_FIN : S_IDLE;
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            state <= S_ISSUE;
            unique case (step)
              ST_WW:  begin ww <= prod[15:0]; step <= ST_WX; end
              ST_WX:  begin
                wx <= prod[35:0];
                sum_wx <= sum_wx + contrib[44:0];
                step <= ST_WY;
              end
              ST_WY:  begin
                wy <= prod[35:0];
                sum_wy <= sum_wy + contrib[44:0];
                step <= ST_WXX;
              end
              ST_WXX: begin sum_wxx <= sum_wxx + contrib; step <= ST_WXY; end
              ST_WXY: begin sum_wxy <= sum_wxy + contrib; step <= ST_WYY; end
              ST_WYY: begin
                sum_wyy    <= sum_wyy + contrib;
                sum_w      <= sum_w + 25'(ww);
                items_used <= items_used + CNT_W'(1);
                state      <= last ? S_FIN : S_IDLE;
              end
              ST_D1, ST_N1, ST_B1, ST_C1, ST_R1: begin
                t1   <= res;
                step <= step_t'(step + 5'd1);
              end
              ST_D2: begin
                dd <= sub_new;
                if (sub_new.neg || sub_new.mag == '0) begin
                  result.status <= STAT_ZDEN;
                  state         <= S_EMIT;
                end else begin
                  step <= ST_N1;
                end
              end
              ST_N2: begin nn <= sub_new; step <= ST_B1; end
              ST_B2: begin bn <= sub_new; step <= ST_SLOPE; end
              ST_SLOPE: begin
                result.slope <= q16_signed(nn.neg, quo, rsp.big);
                step         <= ST_ICPT;
              end
              ST_ICPT: begin
                result.intercept <= q16_signed(bn.neg, quo, rsp.big);
                if (items_used >= CNT_W'(MIN_USED)) step <= ST_C1;
                else state <= S_EMIT;
              end
              ST_C2: begin cc <= sub_new; step <= ST_R1; end
              ST_R2: begin
                rr <= sub_new;
                if (sub_new.neg) state <= S_EMIT;
                else step <= ST_DEN1;
              end
              ST_DEN1: begin den <= prod; step <= ST_DEN2; end
              ST_DEN2: begin den <= prod; step <= ST_VAR; end
              ST_VAR: begin
                result.variance <= (rsp.big || quo[QW-1]) ? '1 : quo[OUT_W-1:0];
                state           <= S_EMIT;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_FIN: begin
          result.slope       <= '0;
          result.intercept   <= '0;
          result.variance    <= '0;
          result.points_used <= 9'(items_used);
          result.status      <= STAT_OK;
          s_s  <= s_from64(64'(sum_w));
          s_x  <= s_from64({{19{sum_wx[44]}}, sum_wx});
          s_y  <= s_from64({{19{sum_wy[44]}}, sum_wy});
          s_xx <= s_from64(sum_wxx);
          s_xy <= s_from64(sum_wxy);
          s_yy <= s_from64(sum_wyy);
          if (items_seen < CNT_W'(MIN_ITEMS)) begin
            result.status <= STAT_FEW;
            state         <= S_EMIT;
          end else begin
            step  <= ST_D1;
            state <= S_ISSUE;
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          sum_w        <= '0;
          sum_wx       <= '0;
          sum_wy       <= '0;
          sum_wxy      <= '0;
          sum_wxx      <= '0;
          sum_wyy      <= '0;
          items_seen   <= '0;
          items_used   <= '0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // a result is a single-cycle strobe
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe held");

  // every result closes a busy stretch
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without work");

  // an accepted closing point always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_item.last_point) |=> busy) else $error("closing point dropped");

  // short sets give zeros
  a_few_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STAT_FEW) |->
      (result.slope == '0 && result.intercept == '0 && result.variance == '0))
    else $error("short set gave non-zero result");

endmodule

>>> hdl/wlf_alu.sv
// Shared bit-serial multiplier and restoring divider.
module wlf_alu import wlf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  alu_req_t      req,
  input  logic [W-1:0]  opa,
  input  logic [W-1:0]  opb,
  output alu_rsp_t      rsp,
  output logic [W-1:0]  prod,
  output logic [QW-1:0] quo
);

  localparam int CW = $clog2(W + 1);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} alu_st_t;

  alu_st_t       st;
  logic [W-1:0]  acc;   // product, or remainder while dividing
  logic [W-1:0]  a_sh;  // multiplicand, or numerator shifting out
  logic [W-1:0]  b_sh;  // multiplier, or divisor
  logic [CW-1:0] cnt;
  logic          done_r;
  logic          big_r;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {acc, a_sh[W-1]};
    rem_sub = rem_sh - {1'b0, b_sh};
    ge      = rem_sh >= {1'b0, b_sh};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st)
        A_IDLE: begin
          if (req.start) begin
            a_sh  <= opa;
            b_sh  <= opb;
            acc   <= '0;
            quo   <= '0;
            big_r <= 1'b0;
            cnt   <= CW'(W);
            st    <= (req.op == OP_MUL) ? A_MUL : A_DIV;
          end
        end
        A_MUL: begin
          if (b_sh == '0) begin
            done_r <= 1'b1;
            st     <= A_IDLE;
          end else begin
            if (b_sh[0]) acc <= acc + a_sh;
            a_sh <= a_sh << 1;
            b_sh <= b_sh >> 1;
          end
        end
        A_DIV: begin
          acc   <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
          quo   <= {quo[QW-2:0], ge};
          big_r <= big_r | quo[QW-1];
          a_sh  <= a_sh << 1;
          cnt   <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            done_r <= 1'b1;
            st     <= A_IDLE;
          end
        end
        default: st <= A_IDLE;
      endcase
    end
  end

  assign prod     = acc;
  assign rsp.done = done_r;
  assign rsp.big  = big_r;

endmodule

>>> bench/weighted_line_fit_variance_unit_tb.sv
// Self-checking testbench for weighted_line_fit_variance_unit: directed and random point sets.
`timescale 1ns / 100ps

module weighted_line_fit_variance_unit_tb;
  import wlf_pkg::*;

  localparam int SET_LIMIT = 256;  // points summed per set; later ones only end the set
  localparam logic [255:0] POS_SAT = 256'h7FFF_FFFF_FFFF;
  localparam logic [255:0] NEG_SAT = 256'h8000_0000_0000;
  localparam logic [255:0] VAR_SAT = 256'hFFFF_FFFF_FFFF;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  wlf_in_t  in_item;
  logic     result_valid;
  wlf_out_t result;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;

  weighted_line_fit_variance_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // points waiting to be sent, fits still owed by the block
  wlf_in_t  pending_points[$];
  wlf_out_t fits_due[$];
  int       sender_idle_pct;
  int       error_count;

  // shadow copy of the block's state
  bit       skip_zero_y_shadow;
  longint   acc_w, acc_wx, acc_wy, acc_wxy, acc_wxx, acc_wyy;
  int       seen_in_set, used_in_set;

  // Q32.16 from a signed numerator and a positive denominator: truncate toward
  // zero, then clamp to the 48-bit signed range
  function automatic logic [47:0] q16_quotient(input logic signed [255:0] num,
                                               input logic [255:0] den);
    logic [255:0] mag;
    logic [255:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag << 16) / den;
    if (num < 0) begin
      if (q > NEG_SAT) q = NEG_SAT;
      return 48'(256'd0 - q);
    end
    if (q > POS_SAT) q = POS_SAT;
    return q[47:0];
  endfunction

  // fold one accepted point into the shadow sums; on the closing point work out
  // the fit the block has to deliver
  task automatic fold_point(input wlf_in_t p);
    longint ww, xv, yv;
    logic signed [255:0] s, sx, sy, sxx, sxy, syy, den, num_a, num_b, spread, resid;
    logic [255:0] var_den, q;
    wlf_out_t fit;
    xv = longint'(p.x_value);
    yv = longint'(p.y_value);
    ww = longint'(p.weight) * longint'(p.weight);
    if (seen_in_set < SET_LIMIT) begin
      seen_in_set++;
      if (!(skip_zero_y_shadow && yv == 0)) begin
        acc_w   += ww;
        acc_wx  += ww * xv;
        acc_wy  += ww * yv;
        acc_wxx += ww * xv * xv;
        acc_wxy += ww * xv * yv;
        acc_wyy += ww * yv * yv;
        used_in_set++;
      end
    end
    if (!p.last_point) return;

    fit = '0;
    fit.points_used = 9'(used_in_set);
    if (seen_in_set < MIN_ITEMS) begin
      fit.status = STAT_FEW;
    end else begin
      s = acc_w;  sx = acc_wx;  sy = acc_wy;
      sxx = acc_wxx;  sxy = acc_wxy;  syy = acc_wyy;
      den = s * sxx - sx * sx;
      if (den <= 0) begin
        fit.status = STAT_ZDEN;
      end else begin
        fit.status = STAT_OK;
        num_a = s * sxy - sx * sy;
        num_b = sxx * sy - sx * sxy;
        fit.slope = q16_quotient(num_a, den);
        fit.intercept = q16_quotient(num_b, den);
        if (used_in_set >= MIN_USED) begin
          spread = s * syy - sy * sy;
          resid = spread * den - num_a * num_a;
          if (resid >= 0) begin
            var_den = s * den * (used_in_set - 2);
            q = (256'(resid) << 16) / var_den;
            if (q > VAR_SAT) q = VAR_SAT;
            fit.variance = q[47:0];
          end
        end
      end
    end
    fits_due.push_back(fit);
    acc_w = 0;  acc_wx = 0;  acc_wy = 0;
    acc_wxy = 0;  acc_wxx = 0;  acc_wyy = 0;
    seen_in_set = 0;  used_in_set = 0;
  endtask

  // point driver: a beat is taken when start is high and busy low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) fold_point(in_item);
      if (!start || !busy) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start   <= 1'b1;
          in_item <= pending_points.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // result monitor: each strobe is one beat, checked against the oldest fit owed
  always @(posedge clk) begin
    wlf_out_t fit;
    if (!rst && result_valid) begin
      if (fits_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %0h", $time, result);
        error_count++;
      end else begin
        fit = fits_due.pop_front();
        check_field("slope", fit.slope, result.slope);
        check_field("intercept", fit.intercept, result.intercept);
        check_field("variance", fit.variance, result.variance);
        check_field("points_used", fit.points_used, result.points_used);
        check_field("status", fit.status, result.status);
      end
    end
  end

  task automatic add_point(input int xv, input int yv, input int wv, input bit last);
    wlf_in_t p;
    p.x_value = 20'(xv);
    p.y_value = 20'(yv);
    p.weight = 8'(wv);
    p.last_point = last;
    pending_points.push_back(p);
  endtask

  // wait until every point is sent and every fit is back, then a short gap
  task automatic drain;
    while (pending_points.size() != 0 || start || fits_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_skip(input bit value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    skip_zero_y_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  // one random point set; mostly near-line data with modest x so the
  // arithmetic stays meaningful, sometimes full-range noise
  task automatic add_random_set(output int n);
    int slope_i, icpt, xv, yv, spread_x;
    bit wild;
    case ($urandom_range(39))
      0:       n = 1;
      1:       n = $urandom_range(257, 260);  // overlong set
      2, 3, 4: n = $urandom_range(20, 60);
      default: n = $urandom_range(2, 10);
    endcase
    wild = ($urandom_range(9) == 0);
    slope_i = $signed($urandom_range(400)) - 200;
    icpt = $signed($urandom_range(20000)) - 10000;
    spread_x = $urandom_range(1, 2000);
    for (int i = 0; i < n; i++) begin
      if (wild) begin
        xv = $urandom;
        yv = $urandom;
      end else begin
        xv = $signed($urandom_range(2 * spread_x)) - spread_x;
        yv = slope_i * xv + icpt + $signed($urandom_range(200)) - 100;
        if ($urandom_range(7) == 0) yv = 0;
      end
      add_point(xv, yv, ($urandom_range(9) == 0) ? 0 : $urandom_range(255), i == n - 1);
    end
  endtask

  initial begin
    int n;
    int phase_count;
    int idle_plan[6];
    bit skip_plan[6];

    idle_plan = '{0, 71, 0, 34, 71, 0};
    skip_plan = '{1, 0, 1, 1, 0, 0};
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    sender_idle_pct = 0;
    error_count = 0;
    skip_zero_y_shadow = 1'b0;
    acc_w = 0;  acc_wx = 0;  acc_wy = 0;
    acc_wxy = 0;  acc_wxx = 0;  acc_wyy = 0;
    seen_in_set = 0;  used_in_set = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: lone point, zero weights, equal x, field extremes,
    // intercept saturation, a zero-weight point among four
    add_point(5, 7, 3, 1);
    add_point(10, 20, 0, 0);  add_point(30, 40, 0, 1);
    add_point(-7, 1, 200, 0);  add_point(-7, 9, 3, 1);
    add_point(-524288, 524287, 255, 0);  add_point(524287, -524288, 255, 1);
    add_point(524286, -524288, 255, 0);  add_point(524287, 524287, 1, 1);
    add_point(1, 0, 17, 0);  add_point(2, 5, 0, 0);  add_point(3, 8, 255, 0);
    add_point(4, 13, 128, 1);
    drain;
    // zero y skipped: a single used point, a set with nothing used, then three used of five
    write_skip(1'b1);
    add_point(3, 0, 9, 0);  add_point(4, 5, 2, 0);  add_point(6, 0, 1, 1);
    add_point(8, 0, 40, 0);  add_point(9, 0, 41, 1);
    add_point(-3, 0, 7, 0);  add_point(1, -2, 7, 0);  add_point(2, 5, 9, 0);
    add_point(5, 0, 7, 0);  add_point(6, 11, 99, 1);
    drain;

    // random phases, each with its own register setting and sender idling
    foreach (idle_plan[ph]) begin
      write_skip(skip_plan[ph]);
      sender_idle_pct = idle_plan[ph];
      phase_count = 0;
      while (phase_count < 300) begin
        add_random_set(n);
        phase_count += n;
      end
      drain;
    end

    repeat (2000) @(posedge clk);
    if (error_count == 0) begin
      $display("weighted_line_fit_variance_unit regression: pass");
    end else begin
      $display("weighted_line_fit_variance_unit regression: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #60_000_000;
    $display("weighted_line_fit_variance_unit regression: fail");
    $finish;
  end

endmodule

>>> sim.f
hdl/wlf_pkg.sv
hdl/wlf_alu.sv
hdl/weighted_line_fit_variance_unit.sv
bench/weighted_line_fit_variance_unit_tb.sv
